### rtl/hsl_to_rgb_converter_macros.svh
// Assertion macros for the HSL to RGB converter.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define HSL_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hsl_to_rgb_converter: invariant violated");
// Checks that an antecedent is followed by a consequent in the next cycle.
`define HSL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter: sequence violated");
`else
`define HSL_ASSERT_ALWAYS(label, cond)
`define HSL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/hsl2rgb_pkg.sv
// Package for the HSL to RGB converter: channel widths, channel indexes and
// the hue segment type. Depends on nothing.
package hsl2rgb_pkg;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// Order of the colour channels in the per-channel arrays.
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// Piece of the hue-to-channel function that a hue position falls in.
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

endpackage

### rtl/hsl2rgb_if.sv
// Valid/ready channel interfaces for the HSL to RGB converter.
// Depends on hsl2rgb_pkg for the colour channel width.
interface hsl2rgb_in_if #(
	parameter int FRAC_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS-1:0] hue;
	logic [FRAC_BITS:0]   saturation;
	logic [FRAC_BITS:0]   lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

interface hsl2rgb_out_if;
	import hsl2rgb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsl_to_rgb_converter.sv
// HSL to RGB colour converter, a six-stage pipeline taking one pixel per clock unless rgb stalls.
// Depends on hsl2rgb_pkg, the channel interfaces and the assertion macro header.
`include "hsl_to_rgb_converter_macros.svh"

// Usage
// The hsl channel carries one pixel per transaction: hue as an unsigned Q0.F
// fraction of a turn, saturation and lightness as unsigned Q1.F values where
// 2^F means 1.0 (F = FRAC_BITS). Values above 1.0 are treated as 1.0.
// The rgb channel returns one transaction per pixel with 8-bit red, green and
// blue, in the order the pixels arrived. Zero saturation gives grey without a
// separate path, since q and p then both equal the lightness.
// A transaction accepted at a rising edge passes through stages 1 to 6 in order,
// and its result shows as valid on rgb from the stage 6 register. Throughput is
// one pixel per clock while rgb does not stall; the figure is set by the multiply
// in the lightness-saturation stage, the one multiplier per channel in the hue
// ramp stage and the shift and subtract of the scale-to-255 stage.
// Every stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so bubbles are squeezed out and the block keeps
// accepting while a finished result waits. When the receiver stalls with the
// pipeline full, hsl.ready drops and every stage holds its transaction.
// The asynchronous reset arst_n empties the pipeline; data registers are not
// reset, as their contents are ignored while the valid bits are low.
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	hsl2rgb_in_if.sink          hsl,
	hsl2rgb_out_if.source       rgb
);
	import hsl2rgb_pkg::*;

	// Width of a Q1.F value and of the widened hue arithmetic.
	localparam int VW = FRAC_BITS + 1;
	localparam int XW = FRAC_BITS + 3;

	localparam logic [VW-1:0]        ONE_V  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [VW-1:0]        HALF_V = {2'b01, {(FRAC_BITS-1){1'b0}}};
	localparam logic [XW-1:0]        ONE_X  = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [XW-1:0]        TWO_X  = ONE_X << 1;
	localparam logic [XW-1:0]        FOUR_X = ONE_X << 2;
	localparam logic [FRAC_BITS-1:0] THIRD  = FRAC_BITS'((2 ** FRAC_BITS) / 3);

	// Valid bits and per-stage advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !v_s6 || rgb.ready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign hsl.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= hsl.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// Stage 1: clamp saturation and lightness to 1.0 and form l*s.
	logic [VW-1:0]        sat_c, lit_c;
	logic [2*VW-1:0]      ls_full;
	logic [FRAC_BITS-1:0] hue_s1;
	logic [VW-1:0]        sat_s1, lit_s1, ls_s1;

	always_comb begin
		sat_c   = (hsl.saturation > ONE_V) ? ONE_V : hsl.saturation;
		lit_c   = (hsl.lightness > ONE_V) ? ONE_V : hsl.lightness;
		ls_full = sat_c * lit_c;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hue_s1 <= hsl.hue;
			sat_s1 <= sat_c;
			lit_s1 <= lit_c;
			ls_s1  <= ls_full[FRAC_BITS +: VW];
		end
	end

	// Stage 2: q from lightness and saturation; hue positions, segments and
	// ramp factors for the three channels. For dark colours l*(1+s) equals
	// l + l*s exactly, since the l*1.0 part carries no fraction.
	logic [VW:0]          q_wide;
	logic [VW-1:0]        q_c;
	logic [FRAC_BITS-1:0] t_pos [NUM_CHAN];
	logic [XW-1:0]        six_t [NUM_CHAN];
	logic [XW-1:0]        three_t [NUM_CHAN];
	logic [XW-1:0]        fall_x [NUM_CHAN];
	seg_t                 seg_c [NUM_CHAN];
	logic [VW-1:0]        fac_c [NUM_CHAN];
	logic [VW-1:0]        lit_s2, q_s2;
	seg_t                 seg_s2 [NUM_CHAN];
	logic [VW-1:0]        fac_s2 [NUM_CHAN];

	always_comb begin
		if (lit_s1 < HALF_V) begin
			q_wide = {1'b0, lit_s1} + {1'b0, ls_s1};
		end else begin
			q_wide = {1'b0, lit_s1} + {1'b0, sat_s1} - {1'b0, ls_s1};
		end
		q_c = (q_wide > {1'b0, ONE_V}) ? ONE_V : q_wide[VW-1:0];

		t_pos[CH_RED]   = hue_s1 + THIRD;
		t_pos[CH_GREEN] = hue_s1;
		t_pos[CH_BLUE]  = hue_s1 - THIRD;

		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			six_t[ch]   = {2'b00, t_pos[ch], 1'b0} + {1'b0, t_pos[ch], 2'b00};
			three_t[ch] = {3'b000, t_pos[ch]} + {2'b00, t_pos[ch], 1'b0};
			fall_x[ch]  = FOUR_X - six_t[ch];
			if (six_t[ch] < ONE_X) begin
				seg_c[ch] = SEG_RISE;
				fac_c[ch] = six_t[ch][VW-1:0];
			end else if (!t_pos[ch][FRAC_BITS-1]) begin
				seg_c[ch] = SEG_HIGH;
				fac_c[ch] = '0;
			end else if (three_t[ch] < TWO_X) begin
				seg_c[ch] = SEG_FALL;
				fac_c[ch] = fall_x[ch][VW-1:0];
			end else begin
				seg_c[ch] = SEG_LOW;
				fac_c[ch] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			lit_s2 <= lit_s1;
			q_s2   <= q_c;
			seg_s2 <= seg_c;
			fac_s2 <= fac_c;
		end
	end

	// Stage 3: p = 2l - q, kept within [0, q], and the span d = q - p.
	logic [VW:0]   two_l;
	logic [VW:0]   p_wide;
	logic [VW-1:0] p_c;
	logic [VW-1:0] p_s3, q_s3, d_s3;
	seg_t          seg_s3 [NUM_CHAN];
	logic [VW-1:0] fac_s3 [NUM_CHAN];

	always_comb begin
		two_l  = {lit_s2, 1'b0};
		p_wide = (two_l > {1'b0, q_s2}) ? (two_l - {1'b0, q_s2}) : '0;
		p_c    = (p_wide > {1'b0, q_s2}) ? q_s2 : p_wide[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			p_s3   <= p_c;
			q_s3   <= q_s2;
			d_s3   <= q_s2 - p_c;
			seg_s3 <= seg_s2;
			fac_s3 <= fac_s2;
		end
	end

	// Stage 4: ramp products d * factor, one multiplier per channel.
	logic [VW-1:0]   p_s4, q_s4;
	logic [2*VW-1:0] ramp_s4 [NUM_CHAN];
	seg_t            seg_s4 [NUM_CHAN];

	always_ff @(posedge clk) begin
		if (adv4) begin
			p_s4   <= p_s3;
			q_s4   <= q_s3;
			seg_s4 <= seg_s3;
			for (int ch = 0; ch < NUM_CHAN; ch++) begin
				ramp_s4[ch] <= d_s3 * fac_s3[ch];
			end
		end
	end

	// Stage 5: pick the channel value for its segment.
	logic [VW:0]   ramp_sum [NUM_CHAN];
	logic [VW-1:0] val_c [NUM_CHAN];
	logic [VW-1:0] val_s5 [NUM_CHAN];

	always_comb begin
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			ramp_sum[ch] = {1'b0, p_s4} + ramp_s4[ch][2*VW-1:FRAC_BITS];
			case (seg_s4[ch])
				SEG_HIGH: val_c[ch] = q_s4;
				SEG_LOW:  val_c[ch] = p_s4;
				default:  val_c[ch] = ramp_sum[ch][VW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			val_s5 <= val_c;
		end
	end

	// Stage 6: scale by 255 with a shift and subtract, truncate and saturate.
	logic [VW+7:0]     scaled [NUM_CHAN];
	logic [CHAN_W:0]   chan_wide [NUM_CHAN];
	logic [CHAN_W-1:0] chan_c [NUM_CHAN];
	logic [CHAN_W-1:0] chan_s6 [NUM_CHAN];

	always_comb begin
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			scaled[ch]    = {val_s5[ch], 8'h00} - {8'h00, val_s5[ch]};
			chan_wide[ch] = scaled[ch][VW+7:FRAC_BITS];
			chan_c[ch]    = chan_wide[ch][CHAN_W] ? CHAN_MAX : chan_wide[ch][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			chan_s6 <= chan_c;
		end
	end

	assign rgb.valid = v_s6;
	assign rgb.red   = chan_s6[CH_RED];
	assign rgb.green = chan_s6[CH_GREEN];
	assign rgb.blue  = chan_s6[CH_BLUE];

	// An accepted transaction always lands in the first stage.
	`HSL_ASSERT_NEXT(a_accept_fills_s1, hsl.valid && hsl.ready, v_s1)
	// The colour bounds hold whenever stage 3 carries a pixel.
	`HSL_ASSERT_ALWAYS(a_p_le_q, !v_s3 || (p_s3 <= q_s3 && q_s3 <= ONE_V))
	// A channel value never exceeds 1.0.
	`HSL_ASSERT_ALWAYS(a_val_range, !v_s5 || (val_s5[CH_RED] <= ONE_V &&
		val_s5[CH_GREEN] <= ONE_V && val_s5[CH_BLUE] <= ONE_V))
	// A blocked stage 4 keeps its pixel.
	`HSL_ASSERT_NEXT(a_stall_holds, v_s4 && !adv5, v_s4)

endmodule
